// ----- rtl/srpq_pkg.sv -----
// ----------------------------------------------------------------------------
// srpq_pkg: shared types and constants of the sorted retransmit queue
// Entry layout, command and status codes, and per-cell control word.
// ----------------------------------------------------------------------------
package srpq_pkg;

    localparam int DEPTH     = 16;
    localparam int MAX_LEVEL = 7;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_RETX   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_DROPPED = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [15:0]       addr;
        logic signed [7:0] strength;
        logic [3:0]        prio;
        logic [1:0]        retries;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ins_entry;
        logic     by_strength;
    } cell_ctrl_t;

endpackage

// ----- rtl/srpq_cell.sv -----
// ----------------------------------------------------------------------------
// srpq_cell: one slot of the sorted entry row
// Compares its entry with the incoming one, passes the placement flag on,
// and takes its neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module srpq_cell (
    input  logic               clk,
    input  srpq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               found_in,
    input  srpq_pkg::entry_t   left_entry,
    input  srpq_pkg::entry_t   right_entry,
    output logic               found_out,
    output logic               addr_hit,
    output srpq_pkg::entry_t   entry
);
    import srpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   goes_before;
    logic   place_here;

    // incoming word belongs in front of this entry
    always_comb
    begin
        goes_before = occupied &&
            ((entry_reg.prio > ctrl.ins_entry.prio) ||
             (ctrl.by_strength && (entry_reg.prio == ctrl.ins_entry.prio) &&
              ($signed(entry_reg.strength) <= $signed(ctrl.ins_entry.strength))));
    end

    assign place_here = !found_in && (goes_before || !occupied);
    assign found_out  = found_in || goes_before || !occupied;
    assign addr_hit   = occupied && (entry_reg.addr == ctrl.ins_entry.addr);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                if (found_in)
                    entry_next = left_entry;
                else if (place_here)
                    entry_next = ctrl.ins_entry;
            end
            OP_POP:    entry_next = right_entry;
            OP_HOLD:   entry_next = entry_reg;
            default:   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- rtl/sorted_retransmit_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_retransmit_priority_queue_core: sorted node list for retransmission
// Holds up to DEPTH node entries sorted by priority number in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (cmd, node_addr, signal_strength, prio_level, retry_count)
//   is taken at a rising edge with start high and busy low. busy stays high
//   for the one execute cycle that follows.
//   In the execute cycle every cell compares its entry with the word at once,
//   a placement flag ripples along the row, and the row shifts right from
//   the placement point (insert) or wholly left (pop) at the closing edge.
//   The result (status, out_valid and the popped entry) is on the outputs
//   for exactly one cycle with done high, the cycle after the execute cycle.
//   Acceptance sets the state register to execute, which then loads done;
//   no command is taken in the execute cycle, the next may come with done
//   high. The flag's ripple through the cells sets the execute cycle's length.
//   The receiver cannot stall: each result must be taken while done is high.
//   Reset empties the list and drops any command in flight; the slots
//   themselves are not cleared, only the fill count.
// ----------------------------------------------------------------------------
module sorted_retransmit_priority_queue_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        cmd,
    input  logic [15:0]       node_addr,
    input  logic signed [7:0] signal_strength,
    input  logic [3:0]        prio_level,
    input  logic [1:0]        retry_count,
    output logic              done,
    output logic [2:0]        status,
    output logic              out_valid,
    output logic [15:0]       out_addr,
    output logic signed [7:0] out_strength,
    output logic [3:0]        out_prio,
    output logic [1:0]        out_retries
);
    import srpq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              done_reg;
    logic [2:0]        status_reg;
    logic [2:0]        status_next;
    logic              out_valid_reg;
    entry_t            out_entry_reg;

    logic [1:0]        cmd_reg;
    entry_t            word_reg;

    cell_ctrl_t        ctrl;
    logic [DEPTH:0]    found;
    entry_t            row   [DEPTH];
    entry_t            left  [DEPTH];
    entry_t            right [DEPTH];
    logic [DEPTH-1:0]  occ;
    logic [DEPTH-1:0]  hit;
    logic              dup;
    logic              full;
    logic              empty;
    logic [4:0]        prio_up;
    logic              pop_ok;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign dup     = |hit;
    assign prio_up = {1'b0, word_reg.prio} + 5'd1;

    // decode of the latched command into cell control and status
    always_comb
    begin
        ctrl.op                = OP_HOLD;
        ctrl.ins_entry         = word_reg;
        ctrl.ins_entry.retries = 2'd0;
        ctrl.by_strength       = 1'b1;
        status_next            = ST_OK;
        fill_next              = fill_reg;
        pop_ok                 = 1'b0;
        unique case (cmd_reg)
            CMD_CREATE:
            begin
                if (dup)
                    status_next = ST_DUP;
                else if (full)
                    status_next = ST_FULL;
                else
                begin
                    ctrl.op   = OP_INSERT;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            CMD_POP:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    ctrl.op   = OP_POP;
                    pop_ok    = 1'b1;
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            CMD_RETX:
            begin
                ctrl.ins_entry.retries = word_reg.retries + 2'd1;
                ctrl.by_strength       = (word_reg.retries == 2'd1);
                if (word_reg.retries == 2'd1)
                    ctrl.ins_entry.prio = prio_up[3:0];
                if (word_reg.retries >= 2'd2)
                    status_next = ST_DROPPED;
                else if ((word_reg.retries == 2'd1) && (prio_up > 5'(MAX_LEVEL)))
                    status_next = ST_DROPPED;
                else if (full)
                    status_next = ST_FULL;
                else
                begin
                    ctrl.op   = OP_INSERT;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            CMD_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        if (state_reg != S_EXEC)
        begin
            ctrl.op   = OP_HOLD;
            fill_next = fill_reg;
        end
    end

    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_row
        assign occ[i]   = (CNT_W'(i) < fill_reg);
        assign left[i]  = (i == 0) ? word_reg : row[(i == 0) ? 0 : i - 1];
        assign right[i] = (i == DEPTH - 1) ? row[i] : row[(i == DEPTH - 1) ? i : i + 1];

        srpq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occ[i]),
            .found_in    (found[i]),
            .left_entry  (left[i]),
            .right_entry (right[i]),
            .found_out   (found[i+1]),
            .addr_hit    (hit[i]),
            .entry       (row[i])
        );
    end

    // command word latch and popped-entry register
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg          <= cmd;
            word_reg.addr    <= node_addr;
            word_reg.strength <= signal_strength;
            word_reg.prio    <= prio_level;
            word_reg.retries <= retry_count;
        end
        if (state_reg == S_EXEC)
            out_entry_reg <= pop_ok ? row[0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg     <= S_IDLE;
                    fill_reg      <= fill_next;
                    done_reg      <= 1'b1;
                    status_reg    <= status_next;
                    out_valid_reg <= pop_ok;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg == S_EXEC);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_valid    = out_valid_reg;
    assign out_addr     = out_entry_reg.addr;
    assign out_strength = out_entry_reg.strength;
    assign out_prio     = out_entry_reg.prio;
    assign out_retries  = out_entry_reg.retries;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> done_reg)
        else $error("no result after execute cycle");

    a_valid_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> done_reg)
        else $error("entry returned without done");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && out_valid_reg) |-> (fill_reg == $past(fill_reg) - CNT_W'(1)))
        else $error("pop did not shrink the list");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && (ctrl.op == OP_INSERT)) |=>
            (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // a list that is not full always has a free cell to place into
    a_insert_placed: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && (ctrl.op == OP_INSERT)) |-> found[DEPTH])
        else $error("insert found no place in the row");

endmodule
